// ===== sv/spk_pkg.sv =====
package spk_pkg;

    localparam int WORD_W = 64;
    localparam int ROT_X  = 8;
    localparam int ROT_Y  = 3;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [0:0] {
        REG_KEY_LOW  = 1'b0,
        REG_KEY_HIGH = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        KS_LOAD,
        KS_EXPAND,
        KS_READY
    } ks_state_t;

    typedef struct packed {
        logic  opcode;
        word_t x_word;
        word_t y_word;
    } in_beat_t;

    typedef struct packed {
        word_t x_result;
        word_t y_result;
    } out_beat_t;

    typedef struct packed {
        word_t x;
        word_t y;
    } word_pair_t;

    function automatic word_t ror(word_t v, int unsigned n);
        return (v >> n) | (v << (WORD_W - n));
    endfunction

    function automatic word_t rol(word_t v, int unsigned n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // x = ror(x,8) + y ^ k; y = rol(y,3) ^ x
    function automatic word_pair_t fwd_round(word_t x, word_t y, word_t k);
        word_pair_t r;
        word_t      a;
        a   = (ror(x, ROT_X) + y) ^ k;
        r.x = a;
        r.y = rol(y, ROT_Y) ^ a;
        return r;
    endfunction

    function automatic word_pair_t inv_round(word_t x, word_t y, word_t k);
        word_pair_t r;
        word_t      a;
        word_t      b;
        b   = ror(y ^ x, ROT_Y);
        a   = (x ^ k) - b;
        r.x = rol(a, ROT_X);
        r.y = b;
        return r;
    endfunction

endpackage

// ===== sv/speck128_block_cipher.sv =====
// Channel | Handshake               | Payload
// --------+-------------------------+-------------------------------------------
// in      | in_valid / in_stall     | in_data  (opcode, x_word, y_word)
// out     | out_valid / out_stall   | out_data (x_result, y_result)
// cfg     | cfg_we                  | cfg_index, cfg_data (key_low, key_high)
//
// One beat per cycle while in_stall is low; a taken beat reaches the output through
// one register per round, ROUNDS rounds, then the output register.
// After reset and after every key write the round keys are expanded one per
// cycle, in a load state and then the expand state, while in_stall is high.
// An output register plus one skid entry lets input flow while a result waits;
// the round pipeline halts only when the skid entry is full.
module speck128_block_cipher #(
    parameter int ROUNDS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  spk_pkg::in_beat_t          in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output spk_pkg::out_beat_t         out_data,
    input  logic                       cfg_we,
    input  spk_pkg::cfg_reg_t          cfg_index,
    input  spk_pkg::word_t             cfg_data
);

    localparam int RND_W = $clog2(ROUNDS);

    // key registers and schedule sequencer
    spk_pkg::word_t      key_low_reg;
    spk_pkg::word_t      key_high_reg;
    spk_pkg::ks_state_t  state_reg;
    spk_pkg::ks_state_t  state_next;
    logic [RND_W-1:0]    cnt_reg;
    logic [RND_W-1:0]    cnt_next;
    spk_pkg::word_t      ka_reg;
    spk_pkg::word_t      kb_reg;
    spk_pkg::word_pair_t ks_step;
    spk_pkg::word_t      rk_reg [ROUNDS];

    // round pipeline
    logic [ROUNDS-1:0]   v_reg;
    spk_pkg::in_beat_t   p_reg  [ROUNDS];
    spk_pkg::in_beat_t   p_next [ROUNDS];
    logic                pipe_en;
    logic                in_accept;

    // output register and skid entry
    logic                out_valid_reg;
    spk_pkg::out_beat_t  out_data_reg;
    logic                skid_valid_reg;
    spk_pkg::out_beat_t  skid_data_reg;
    spk_pkg::out_beat_t  pipe_tail;
    logic                push;
    logic                pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                spk_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                spk_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spk_pkg::KS_LOAD;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            spk_pkg::KS_LOAD:
            begin
                state_next = spk_pkg::KS_EXPAND;
                cnt_next   = '0;
            end
            spk_pkg::KS_EXPAND:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == RND_W'(ROUNDS - 1))
                begin
                    state_next = spk_pkg::KS_READY;
                end
            end
            spk_pkg::KS_READY:
            begin
                state_next = spk_pkg::KS_READY;
            end
            default:
            begin
                state_next = spk_pkg::KS_LOAD;
            end
        endcase
        // a new key restarts the schedule
        if (cfg_we)
        begin
            state_next = spk_pkg::KS_LOAD;
        end
    end

    assign ks_step = spk_pkg::fwd_round(kb_reg, ka_reg, spk_pkg::WORD_W'(cnt_reg));

    always_ff @(posedge clk)
    begin
        if (state_reg == spk_pkg::KS_LOAD)
        begin
            ka_reg <= key_low_reg;
            kb_reg <= key_high_reg;
        end
        else if (state_reg == spk_pkg::KS_EXPAND)
        begin
            rk_reg[cnt_reg] <= ka_reg;
            kb_reg          <= ks_step.x;
            ka_reg          <= ks_step.y;
        end
    end

    // pipeline control
    assign pipe_en   = !skid_valid_reg;
    assign in_stall  = skid_valid_reg || (state_reg != spk_pkg::KS_READY);
    assign in_accept = in_valid && !in_stall;

    for (genvar i = 0; i < ROUNDS; i++)
    begin : g_round
        spk_pkg::in_beat_t   src;
        spk_pkg::word_pair_t fwd;
        spk_pkg::word_pair_t inv;

        if (i == 0)
        begin : g_first
            assign src = in_data;
        end
        else
        begin : g_rest
            assign src = p_reg[i-1];
        end

        assign fwd = spk_pkg::fwd_round(src.x_word, src.y_word, rk_reg[i]);
        assign inv = spk_pkg::inv_round(src.x_word, src.y_word, rk_reg[ROUNDS-1-i]);

        always_comb
        begin
            p_next[i].opcode = src.opcode;
            if (src.opcode == spk_pkg::OP_DECRYPT)
            begin
                p_next[i].x_word = inv.x;
                p_next[i].y_word = inv.y;
            end
            else
            begin
                p_next[i].x_word = fwd.x;
                p_next[i].y_word = fwd.y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (pipe_en)
        begin
            v_reg <= {v_reg[ROUNDS-2:0], in_accept};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int i = 0; i < ROUNDS; i++)
            begin
                p_reg[i] <= p_next[i];
            end
        end
    end

    // output side
    assign pipe_tail.x_result = p_reg[ROUNDS-1].x_word;
    assign pipe_tail.y_result = p_reg[ROUNDS-1].y_word;
    assign push = pipe_en && v_reg[ROUNDS-1];
    assign pop  = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= pipe_tail;
            end
            else
            begin
                out_data_reg <= pipe_tail;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_accept_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> state_reg == spk_pkg::KS_READY)
        else $error("beat accepted while round keys are being expanded");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a beat with the output register empty");

    a_load_to_expand: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == spk_pkg::KS_LOAD && !cfg_we
        |=> state_reg == spk_pkg::KS_EXPAND && cnt_reg == '0)
        else $error("schedule load did not start expansion at round zero");

    a_tail_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> out_valid_reg)
        else $error("beat leaving the round pipeline was dropped");

    a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(v_reg))
        else $error("round pipeline moved while the skid entry was full");
`endif

endmodule
